[rtl/ssd_pkg.sv]
// Shared types, codes and constants of the serial settings memory.
`default_nettype none

package ssd_pkg;

    // Bus operation codes carried by each input item.
    typedef enum logic [1:0] {
        OP_IMM_WRITE  = 2'd0,
        OP_IMM_READ   = 2'd1,
        OP_XFER_WRITE = 2'd2,
        OP_XFER_READ  = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_SIZE    = 3'd1,
        ST_ADDR_OUT    = 3'd2,
        ST_UNKNOWN_CMD = 3'd3,
        ST_READ_UNSUP  = 3'd4,
        ST_NO_WRITE    = 3'd5,
        ST_OVERRUN     = 3'd6,
        ST_NO_READ     = 3'd7
    } t_status;

    // Command word layout: chip address in bits 30..6, write flag in bit 31.
    localparam int ADDR_W        = 25;
    localparam int ADDR_LSB      = 6;
    localparam int CMD_WRITE_BIT = 31;

    localparam logic [31:0]       CMD_READ   = 32'h2000_0100;
    localparam logic [ADDR_W-1:0] ROM_LIMIT  = 25'h080_0000;
    localparam logic [ADDR_W-1:0] STORE_BASE = CMD_READ[ADDR_LSB +: ADDR_W];

    localparam logic [6:0] IMM_BYTES   = 7'd4;
    localparam logic [6:0] MAX_RESULTS = 7'd64;

    // Two bytes of the store come out of reset as 0xFF.
    localparam int FF_BYTE_A = 58;
    localparam int FF_BYTE_B = 59;

    function automatic logic [7:0] reset_byte(input int unsigned idx);
        return ((idx == FF_BYTE_A) || (idx == FF_BYTE_B)) ? 8'hFF : 8'h00;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the presented item this cycle
        logic pay_step;   // store the next payload byte
        logic read_emit;  // move the current read byte into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;      // output register can take a result this cycle
        logic acc_pay_more;  // accepted payload word needs further byte writes
        logic acc_read;      // accepted item starts a transfer read stream
        logic pay_last;      // current payload step is the final one
        logic rd_last;       // current read byte is the final one
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/ssd_datapath.sv]
// Datapath: command decode, settings store, pointers and the output register.
`default_nettype none

module ssd_datapath #(
    parameter int STORE_BYTES = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ssd_pkg::t_dp_cmd     i_cmd,
    output ssd_pkg::t_dp_sts     o_sts,
    input  wire  [1:0]           i_operation,
    input  wire  [31:0]          i_word,
    input  wire  [6:0]           i_length,
    input  wire  [5:0]           i_byte_index,
    input  wire  [7:0]           i_data_byte,
    input  wire                  i_stall,
    output logic                 o_valid,
    output logic [2:0]           o_status,
    output logic [7:0]           o_read_byte,
    output logic                 o_last
);

    localparam int PTR_W = $clog2(STORE_BYTES + 1);
    localparam int IDX_W = $clog2(STORE_BYTES);
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(STORE_BYTES - 1);

    // Architectural state.
    logic [PTR_W-1:0]        r_ptr;
    logic                    r_phase;
    logic                    r_cmd_rom;
    logic                    r_cmd_read;

    // Payload word being written out byte by byte.
    logic [31:0]             r_shift;
    logic [1:0]              r_left;

    // Transfer read stream.
    logic [6:0]              r_len;
    logic [6:0]              r_ri;
    logic [6:0]              ri_next;

    // Store, per-byte written flags and registered read data.
    logic [7:0]              r_mem [STORE_BYTES];
    logic [STORE_BYTES-1:0]  r_vld;
    logic [7:0]              r_rd_mem;
    logic [7:0]              r_rd_dflt;
    logic                    r_rd_vld;
    logic [7:0]              rd_byte;

    // Output register.
    logic                    r_out_valid;
    ssd_pkg::t_status        r_out_status;
    logic [7:0]              r_out_byte;
    logic                    r_out_last;

    // Decode of the presented item.
    logic [ssd_pkg::ADDR_W-1:0] cmd_addr;
    logic [ssd_pkg::ADDR_W-1:0] cmd_off;
    logic                    cmd_in_store;
    logic                    cmd_is_read;
    logic                    cmd_rom;
    logic                    cmd_wr_ok;
    logic                    pay_now;
    logic                    overrun;

    ssd_pkg::t_status        acc_status;
    logic                    acc_single;
    logic                    acc_pay;
    logic                    acc_read;
    logic                    acc_xwr;
    logic                    acc_cmd;

    logic                    load_single;
    logic                    read_start;
    logic                    read_next;
    logic                    out_free;

    logic                    we;
    logic [IDX_W-1:0]        wa;
    logic [7:0]              wd;
    logic                    re;
    logic [IDX_W-1:0]        ra;

    // Command word fields and range checks.
    assign cmd_addr     = i_word[ssd_pkg::ADDR_LSB +: ssd_pkg::ADDR_W];
    assign cmd_off      = cmd_addr - ssd_pkg::STORE_BASE;
    assign cmd_in_store = (cmd_addr >= ssd_pkg::STORE_BASE) && (32'(cmd_off) < STORE_BYTES);
    assign cmd_is_read  = (i_word == ssd_pkg::CMD_READ);
    assign cmd_rom      = (cmd_addr < ssd_pkg::ROM_LIMIT);
    assign cmd_wr_ok    = !cmd_is_read && i_word[ssd_pkg::CMD_WRITE_BIT] && cmd_in_store;
    assign pay_now      = r_phase && (32'(r_ptr) < STORE_BYTES);
    assign overrun      = (32'(r_ptr) + 32'(i_length)) > STORE_BYTES;

    // Classify the presented item and work out its single-result status.
    always_comb begin
        acc_status = ssd_pkg::ST_OK;
        acc_single = 1'b1;
        acc_pay    = 1'b0;
        acc_read   = 1'b0;
        acc_xwr    = 1'b0;
        acc_cmd    = 1'b0;
        unique case (ssd_pkg::t_op'(i_operation))
            ssd_pkg::OP_IMM_WRITE: begin
                if (i_length != ssd_pkg::IMM_BYTES) begin
                    acc_status = ssd_pkg::ST_BAD_SIZE;
                end else if (pay_now) begin
                    acc_pay = 1'b1;
                end else begin
                    acc_cmd = 1'b1;
                    if (!cmd_is_read && i_word[ssd_pkg::CMD_WRITE_BIT] && !cmd_in_store) begin
                        acc_status = ssd_pkg::ST_ADDR_OUT;
                    end else if (!cmd_is_read && !i_word[ssd_pkg::CMD_WRITE_BIT]
                                 && !cmd_rom) begin
                        acc_status = ssd_pkg::ST_UNKNOWN_CMD;
                    end
                end
            end
            ssd_pkg::OP_IMM_READ: begin
                acc_status = ssd_pkg::ST_READ_UNSUP;
            end
            ssd_pkg::OP_XFER_WRITE: begin
                if (!r_phase) begin
                    acc_status = ssd_pkg::ST_NO_WRITE;
                end else if (overrun) begin
                    acc_status = ssd_pkg::ST_OVERRUN;
                end else begin
                    acc_xwr = ({1'b0, i_byte_index} < i_length);
                end
            end
            ssd_pkg::OP_XFER_READ: begin
                if (!r_cmd_rom && !r_cmd_read) begin
                    acc_status = ssd_pkg::ST_NO_READ;
                end else if ((!r_cmd_rom && (32'(i_length) > STORE_BYTES))
                             || (i_length > ssd_pkg::MAX_RESULTS)) begin
                    acc_status = ssd_pkg::ST_BAD_SIZE;
                end else begin
                    acc_single = 1'b0;
                    acc_read   = (i_length != 7'd0);
                end
            end
        endcase
    end

    assign out_free    = !r_out_valid || !i_stall;
    assign load_single = i_cmd.accept && acc_single;
    assign read_start  = i_cmd.accept && acc_read;
    assign ri_next     = r_ri + 7'd1;
    assign read_next   = i_cmd.read_emit && (ri_next != r_len);

    // Status back to the controller.
    always_comb begin
        o_sts.out_free     = out_free;
        o_sts.acc_pay_more = acc_pay && (r_ptr != PTR_END);
        o_sts.acc_read     = acc_read;
        o_sts.pay_last     = (r_left == 2'd1) || (r_ptr == PTR_END);
        o_sts.rd_last      = (ri_next == r_len);
    end

    // Command, pointer and phase state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_phase    <= 1'b0;
            r_cmd_rom  <= 1'b1;
            r_cmd_read <= 1'b0;
        end else begin
            if (i_cmd.accept && acc_cmd) begin
                r_cmd_rom  <= cmd_rom;
                r_cmd_read <= cmd_is_read;
                r_phase    <= cmd_wr_ok;
                if (cmd_wr_ok) begin
                    r_ptr <= PTR_W'(cmd_off);
                end
            end
            if ((i_cmd.accept && acc_pay) || i_cmd.pay_step) begin
                r_ptr <= r_ptr + PTR_W'(1);
            end
        end
    end

    // Payload word and read stream counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && acc_pay) begin
            r_shift <= {i_word[23:0], 8'h00};
            r_left  <= 2'd3;
        end else if (i_cmd.pay_step) begin
            r_shift <= {r_shift[23:0], 8'h00};
            r_left  <= r_left - 2'd1;
        end
        if (read_start) begin
            r_len <= i_length;
            r_ri  <= 7'd0;
        end else if (read_next) begin
            r_ri <= ri_next;
        end
    end

    // Store write port selection: one byte per cycle.
    always_comb begin
        we = i_cmd.pay_step;
        wa = IDX_W'(r_ptr);
        wd = r_shift[31:24];
        if (i_cmd.accept && acc_pay) begin
            we = 1'b1;
            wd = i_word[31:24];
        end
        if (i_cmd.accept && acc_xwr) begin
            we = 1'b1;
            wa = IDX_W'(32'(r_ptr) + 32'(i_byte_index));
            wd = i_data_byte;
        end
    end

    assign re = read_start || read_next;
    assign ra = read_start ? '0 : IDX_W'(ri_next);

    // Settings store with registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rd_mem  <= r_mem[ra];
            r_rd_vld  <= r_vld[ra];
            r_rd_dflt <= ssd_pkg::reset_byte(32'(ra));
        end
    end

    // Written flags: an unwritten byte reads as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[wa] <= 1'b1;
        end
    end

    assign rd_byte = r_cmd_rom ? 8'h00 : (r_rd_vld ? r_rd_mem : r_rd_dflt);

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_single || i_cmd.read_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load_single) begin
            r_out_status <= acc_status;
            r_out_byte   <= 8'h00;
            r_out_last   <= 1'b1;
        end else if (i_cmd.read_emit) begin
            r_out_status <= ssd_pkg::ST_OK;
            r_out_byte   <= rd_byte;
            r_out_last   <= (ri_next == r_len);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_read_byte = r_out_byte;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

[rtl/ssd_ctrl.sv]
// Controller: input handshake and sequencing of payload writes and read streams.
`default_nettype none

module ssd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  ssd_pkg::t_dp_sts  i_sts,
    output ssd_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAYLOAD,
        S_READ
    } t_state;

    t_state r_state;
    logic   take;

    // An item is taken only when idle and the output register has room.
    assign take    = (r_state == S_IDLE) && i_sts.out_free;
    assign o_stall = !take;

    always_comb begin
        o_cmd.accept    = take && i_valid;
        o_cmd.pay_step  = (r_state == S_PAYLOAD);
        o_cmd.read_emit = (r_state == S_READ) && i_sts.out_free;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.accept && i_sts.acc_pay_more) begin
                        r_state <= S_PAYLOAD;
                    end else if (o_cmd.accept && i_sts.acc_read) begin
                        r_state <= S_READ;
                    end
                end
                S_PAYLOAD: begin
                    if (i_sts.pay_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (i_sts.out_free && i_sts.rd_last) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/serial_settings_sram_device_unit.sv]
// Top level of the serial settings memory: controller plus datapath.
`default_nettype none

// A settings store of STORE_BYTES bytes answering serial bus items. Immediate
// commands, immediate reads and transfer-write bytes each give one result; an
// item is taken whenever the block is idle and its output register is empty or
// being emptied. A payload word stores up to four bytes through the single store
// write port, one byte per cycle, so it occupies the block until its last byte
// is written. A transfer read of N bytes streams N results through a registered
// store read, one per cycle while the output is not stalled, and the next item
// is taken once the last byte has entered the output register. Store reset
// values come from per-byte written flags, so no clearing pass follows reset.
module serial_settings_sram_device_unit #(
    parameter int STORE_BYTES = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_operation,
    input  wire  [31:0] i_word,
    input  wire  [6:0]  i_length,
    input  wire  [5:0]  i_byte_index,
    input  wire  [7:0]  i_data_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_read_byte,
    output logic        o_last
);

    ssd_pkg::t_dp_cmd cmd;
    ssd_pkg::t_dp_sts sts;

    // Sequencer.
    ssd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Store, decode and output stage.
    ssd_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_operation  (i_operation),
        .i_word       (i_word),
        .i_length     (i_length),
        .i_byte_index (i_byte_index),
        .i_data_byte  (i_data_byte),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_read_byte  (o_read_byte),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

[rtl/ssd_checker.sv]
// Port-level checks of the serial settings memory and their bind to the top level.
`default_nettype none

module ssd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire [1:0]  i_operation,
    input wire [6:0]  i_length,
    input wire        o_valid,
    input wire        i_stall,
    input wire [2:0]  o_status,
    input wire [7:0]  o_read_byte,
    input wire        o_last
);

    // An error result is always the only result of its item.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ssd_pkg::ST_OK)) |-> (o_last && (o_read_byte == 8'h00)))
        else $error("error result is not a lone result with zero data");

    // An immediate read item is answered in the next cycle as unsupported.
    a_imm_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_operation == ssd_pkg::OP_IMM_READ))
        |=> (o_valid && (o_status == ssd_pkg::ST_READ_UNSUP) && o_last))
        else $error("immediate read not answered as unsupported");

    // An immediate write of the wrong size is answered next cycle as bad size.
    a_bad_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_operation == ssd_pkg::OP_IMM_WRITE)
         && (i_length != ssd_pkg::IMM_BYTES))
        |=> (o_valid && (o_status == ssd_pkg::ST_BAD_SIZE) && o_last))
        else $error("wrong-size immediate write not answered as bad size");

    // A stalled result holds its item.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall)
        |=> (o_valid && $stable(o_status) && $stable(o_read_byte) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind serial_settings_sram_device_unit ssd_checker u_ssd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_operation (i_operation),
    .i_length    (i_length),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_read_byte (o_read_byte),
    .o_last      (o_last)
);

`default_nettype wire

[dv/tb_serial_settings_sram_device_unit.sv]
// Testbench of the serial settings memory: a directed table, random bus sessions, a running model.
`timescale 1ns / 1ps

module tb_serial_settings_sram_device_unit;

    localparam int STORE_BYTES  = 64;
    localparam int RAND_ITEMS   = 180;
    localparam int QUIET_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        ssd_pkg::t_op     op;
        logic [31:0]      word;
        logic [6:0]       len;
        logic [5:0]       idx;
        logic [7:0]       data;
    } t_item;

    typedef struct {
        ssd_pkg::t_status status;
        logic [7:0]       rbyte;
        logic             last;
    } t_answer;

    typedef struct {
        t_item            item;
        bit               typed;
        ssd_pkg::t_status typed_st;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_operation;
    logic [31:0] i_word;
    logic [6:0]  i_length;
    logic [5:0]  i_byte_index;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_read_byte;
    logic        o_last;

    // Mirror of the block's state, kept in step with every accepted item.
    logic [7:0]  mirror_store [STORE_BYTES];
    logic [31:0] mirror_cmd;
    int unsigned mirror_ptr;
    bit          mirror_wphase;

    t_answer     item_answers [$];
    t_answer     awaited_answers [$];
    t_row        dir_rows [$];

    int          errors;
    int          items_sent;
    int          answers_seen;
    int          tx_pct;
    bit          no_idle;
    int          idle_cycles;

    serial_settings_sram_device_unit #(
        .STORE_BYTES(STORE_BYTES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_word       (i_word),
        .i_length     (i_length),
        .i_byte_index (i_byte_index),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_read_byte  (o_read_byte),
        .o_last       (o_last)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_item mk(ssd_pkg::t_op op, logic [31:0] word, logic [6:0] len,
                                 logic [5:0] idx, logic [7:0] data);
        t_item it;
        it.op   = op;
        it.word = word;
        it.len  = len;
        it.idx  = idx;
        it.data = data;
        return it;
    endfunction

    function automatic logic [31:0] write_cmd_word(logic [ssd_pkg::ADDR_W-1:0] addr,
                                                   logic [5:0] low);
        return {1'b1, addr, low};
    endfunction

    // Works out the answers of one item and advances the mirrored state.
    function automatic void predict_answers(input t_item it);
        t_answer                    r;
        logic [ssd_pkg::ADDR_W-1:0] addr;
        int unsigned                n;
        bit                         taken;
        bit                         rom;
        item_answers.delete();
        r.status = ssd_pkg::ST_OK;
        r.rbyte  = 8'h00;
        r.last   = 1'b1;
        case (it.op)
            ssd_pkg::OP_IMM_WRITE: begin
                if (it.len != ssd_pkg::IMM_BYTES) begin
                    r.status = ssd_pkg::ST_BAD_SIZE;
                end else begin
                    taken = 1'b0;
                    // A selected write takes the word as payload until the pointer passes the end.
                    if (mirror_wphase) begin
                        if (mirror_ptr >= STORE_BYTES) begin
                            mirror_wphase = 1'b0;
                        end else begin
                            n = STORE_BYTES - mirror_ptr;
                            if (n > 4) n = 4;
                            for (int i = 0; i < n; i++)
                                mirror_store[mirror_ptr + i] = it.word[8*(3-i) +: 8];
                            mirror_ptr += n;
                            taken = 1'b1;
                        end
                    end
                    if (!taken) begin
                        mirror_cmd = it.word;
                        addr = it.word[ssd_pkg::ADDR_LSB +: ssd_pkg::ADDR_W];
                        if (it.word == ssd_pkg::CMD_READ) begin
                            mirror_wphase = 1'b0;
                        end else if (it.word[ssd_pkg::CMD_WRITE_BIT]) begin
                            if (addr < ssd_pkg::STORE_BASE
                                || addr - ssd_pkg::STORE_BASE >= STORE_BYTES) begin
                                r.status = ssd_pkg::ST_ADDR_OUT;
                            end else begin
                                mirror_ptr    = addr - ssd_pkg::STORE_BASE;
                                mirror_wphase = 1'b1;
                            end
                        end else if (addr >= ssd_pkg::ROM_LIMIT) begin
                            r.status = ssd_pkg::ST_UNKNOWN_CMD;
                        end
                    end
                end
                item_answers.push_back(r);
            end
            ssd_pkg::OP_IMM_READ: begin
                r.status = ssd_pkg::ST_READ_UNSUP;
                item_answers.push_back(r);
            end
            ssd_pkg::OP_XFER_WRITE: begin
                if (!mirror_wphase)
                    r.status = ssd_pkg::ST_NO_WRITE;
                else if (mirror_ptr + it.len > STORE_BYTES)
                    r.status = ssd_pkg::ST_OVERRUN;
                else if (it.idx < it.len && mirror_ptr + it.idx < STORE_BYTES)
                    mirror_store[mirror_ptr + it.idx] = it.data;
                item_answers.push_back(r);
            end
            default: begin
                rom = mirror_cmd[ssd_pkg::ADDR_LSB +: ssd_pkg::ADDR_W] < ssd_pkg::ROM_LIMIT;
                if (!rom && mirror_cmd != ssd_pkg::CMD_READ) begin
                    r.status = ssd_pkg::ST_NO_READ;
                    item_answers.push_back(r);
                end else if ((!rom && it.len > STORE_BYTES)
                             || it.len > ssd_pkg::MAX_RESULTS) begin
                    r.status = ssd_pkg::ST_BAD_SIZE;
                    item_answers.push_back(r);
                end else begin
                    // A boot-ROM read streams zeros, a settings read streams the store.
                    for (int i = 0; i < it.len; i++) begin
                        r.rbyte = rom ? 8'h00 : mirror_store[i];
                        r.last  = (i + 1 == it.len);
                        item_answers.push_back(r);
                    end
                end
            end
        endcase
    endfunction

    // Offers one item, holds it until taken, then maybe idles for a burst.
    task automatic issue_item(input t_item it, input bit typed,
                              input ssd_pkg::t_status typed_st);
        t_answer fixed;
        @(negedge i_clk);
        predict_answers(it);
        if (typed) begin
            fixed.status = typed_st;
            fixed.rbyte  = 8'h00;
            fixed.last   = 1'b1;
            awaited_answers.push_back(fixed);
        end else begin
            foreach (item_answers[k]) awaited_answers.push_back(item_answers[k]);
        end
        i_operation  <= it.op;
        i_word       <= it.word;
        i_length     <= it.len;
        i_byte_index <= it.idx;
        i_data_byte  <= it.data;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        items_sent++;
        if (items_sent % 25 == 0) begin
            case ($urandom_range(0, 2))
                0:       tx_pct = 0;
                1:       tx_pct = 20;
                default: tx_pct = 50;
            endcase
        end
        if (!no_idle && $urandom_range(0, 99) < tx_pct) begin
            repeat ($urandom_range(1, 14)) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
    endtask

    // Pushes payload words until a selected write can no longer absorb a command.
    task automatic leave_payload();
        while (mirror_wphase && mirror_ptr < STORE_BYTES)
            issue_item(mk(ssd_pkg::OP_IMM_WRITE, $urandom, ssd_pkg::IMM_BYTES,
                          $urandom_range(0, 63), $urandom_range(0, 255)),
                       1'b0, ssd_pkg::ST_OK);
    endtask

    function automatic logic [6:0] read_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) return $urandom_range(1, 8);
        if (pick < 90) return $urandom_range(9, 64);
        if (pick < 95) return 7'd0;
        return $urandom_range(65, 127);
    endfunction

    function automatic void add_row(ssd_pkg::t_op op, logic [31:0] word, logic [6:0] len,
                                    logic [5:0] idx, logic [7:0] data,
                                    bit typed, ssd_pkg::t_status st);
        t_row row;
        row.item     = mk(op, word, len, idx, data);
        row.typed    = typed;
        row.typed_st = st;
        dir_rows.push_back(row);
    endfunction

    // Directed table: extremes, every operation and every error status.
    function automatic void load_directed();
        add_row(ssd_pkg::OP_XFER_READ,  32'h0,         7'd1,   6'd0,  8'h00,
                1, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_IMM_WRITE,  32'hFFFF_FFFF, 7'd0,   6'd0,  8'h00,
                1, ssd_pkg::ST_BAD_SIZE);
        add_row(ssd_pkg::OP_IMM_WRITE,  32'h0,         7'd127, 6'd63, 8'hFF,
                1, ssd_pkg::ST_BAD_SIZE);
        add_row(ssd_pkg::OP_IMM_READ,   32'hFFFF_FFFF, 7'd4,   6'd0,  8'h00,
                1, ssd_pkg::ST_READ_UNSUP);
        add_row(ssd_pkg::OP_XFER_WRITE, 32'h0,         7'd64,  6'd63, 8'hFF,
                1, ssd_pkg::ST_NO_WRITE);
        add_row(ssd_pkg::OP_IMM_WRITE,  ssd_pkg::CMD_READ + 32'h40, ssd_pkg::IMM_BYTES,
                6'd0, 8'h00, 1, ssd_pkg::ST_UNKNOWN_CMD);
        add_row(ssd_pkg::OP_XFER_READ,  32'h0,         7'd5,   6'd0,  8'h00,
                1, ssd_pkg::ST_NO_READ);
        add_row(ssd_pkg::OP_IMM_WRITE,  ssd_pkg::CMD_READ, ssd_pkg::IMM_BYTES, 6'd0, 8'h00,
                1, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_XFER_READ,  32'h0,         7'd64,  6'd0,  8'h00,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_XFER_READ,  32'h0,         7'd65,  6'd0,  8'h00,
                1, ssd_pkg::ST_BAD_SIZE);
        add_row(ssd_pkg::OP_XFER_READ,  32'h0,         7'd0,   6'd0,  8'h00,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_IMM_WRITE,  write_cmd_word(ssd_pkg::STORE_BASE - 1, 6'h3F),
                ssd_pkg::IMM_BYTES, 6'd0, 8'h00, 1, ssd_pkg::ST_ADDR_OUT);
        add_row(ssd_pkg::OP_IMM_WRITE,
                write_cmd_word(ssd_pkg::STORE_BASE + STORE_BYTES, 6'h00),
                ssd_pkg::IMM_BYTES, 6'd0, 8'h00, 1, ssd_pkg::ST_ADDR_OUT);
        // Highest boot-ROM chip address.
        add_row(ssd_pkg::OP_IMM_WRITE,  32'h1FFF_FFFF, ssd_pkg::IMM_BYTES, 6'd0, 8'h00,
                1, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_XFER_READ,  32'h0,         7'd64,  6'd0,  8'h00,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_XFER_READ,  32'h0,         7'd127, 6'd0,  8'h00,
                1, ssd_pkg::ST_BAD_SIZE);
        // Payload that runs off the end, transfer writes at the end, then the word that closes the write.
        add_row(ssd_pkg::OP_IMM_WRITE,  write_cmd_word(ssd_pkg::STORE_BASE + 62, 6'h00),
                ssd_pkg::IMM_BYTES, 6'd0, 8'h00, 0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_IMM_WRITE,  32'hDEAD_BEEF, ssd_pkg::IMM_BYTES, 6'd0, 8'h00,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_XFER_WRITE, 32'h0,         7'd1,   6'd0,  8'h55,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_XFER_WRITE, 32'h0,         7'd0,   6'd0,  8'h55,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_IMM_WRITE,  32'hFFFF_FFFF, ssd_pkg::IMM_BYTES, 6'd0, 8'h00,
                0, ssd_pkg::ST_OK);
        // Write from offset zero with transfer bytes inside and beyond the length, then payload words.
        add_row(ssd_pkg::OP_IMM_WRITE,  write_cmd_word(ssd_pkg::STORE_BASE, 6'h00),
                ssd_pkg::IMM_BYTES, 6'd0, 8'h00, 0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_XFER_WRITE, 32'h0,         7'd64,  6'd63, 8'hAA,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_XFER_WRITE, 32'h0,         7'd10,  6'd12, 8'h55,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_IMM_WRITE,  32'h0123_4567, ssd_pkg::IMM_BYTES, 6'd0, 8'h00,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_IMM_WRITE,  32'h0,         ssd_pkg::IMM_BYTES, 6'd0, 8'h00,
                0, ssd_pkg::ST_OK);
        add_row(ssd_pkg::OP_XFER_WRITE, 32'h0,         7'd4,   6'd3,  8'h00,
                0, ssd_pkg::ST_OK);
    endfunction

    // Receiver: random stall bursts, one long hold-off, no stalls near the end.
    initial begin : rx_side
        int rx_pct;
        int burst;
        int hold_left;
        int cyc;
        bit hold_done;
        rx_pct    = 10;
        burst     = 0;
        hold_left = 0;
        cyc       = 0;
        hold_done = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       rx_pct = 0;
                    1:       rx_pct = 10;
                    default: rx_pct = 30;
                endcase
            end
            if (!hold_done && answers_seen >= 40) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (no_idle) begin
                burst = 0;
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < rx_pct) begin
                burst = $urandom_range(0, 13);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Compares each accepted answer with the oldest one awaited.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            answers_seen++;
            if (awaited_answers.size() == 0) begin
                $error("answer with none awaited: status %0d, read_byte %0h, last %0b",
                       o_status, o_read_byte, o_last);
                errors++;
            end else begin
                want = awaited_answers.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    errors++;
                end
                if (o_read_byte !== want.rbyte) begin
                    $error("read_byte: expected %0h, actual %0h", want.rbyte, o_read_byte);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Reset, directed table, random sessions, drain and verdict.
    initial begin : tx_side
        int                         pick;
        int                         steps;
        int                         n_dir;
        logic [ssd_pkg::ADDR_W-1:0] addr;
        logic [6:0]                 len;
        logic [5:0]                 idx;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_operation  = ssd_pkg::OP_IMM_WRITE;
        i_word       = 32'h0;
        i_length     = 7'd0;
        i_byte_index = 6'd0;
        i_data_byte  = 8'h00;
        errors       = 0;
        items_sent   = 0;
        answers_seen = 0;
        tx_pct       = 20;
        no_idle      = 1'b0;
        idle_cycles  = 0;
        for (int i = 0; i < STORE_BYTES; i++)
            mirror_store[i] = (i == ssd_pkg::FF_BYTE_A || i == ssd_pkg::FF_BYTE_B)
                              ? 8'hFF : 8'h00;
        mirror_cmd    = 32'h0;
        mirror_ptr    = 0;
        mirror_wphase = 1'b0;
        load_directed();
        n_dir = dir_rows.size();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            issue_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].typed_st);

        // Random part: mostly well-formed sessions with random content, some noise.
        while (items_sent < n_dir + RAND_ITEMS) begin
            if (items_sent >= n_dir + RAND_ITEMS - QUIET_ITEMS) no_idle = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                leave_payload();
                case ($urandom_range(0, 9))
                    0:       addr = $urandom;
                    1:       addr = $urandom_range(0, 1)
                                   ? ssd_pkg::STORE_BASE - $urandom_range(1, 4)
                                   : ssd_pkg::STORE_BASE + STORE_BYTES + $urandom_range(0, 3);
                    2, 3:    addr = ssd_pkg::STORE_BASE + $urandom_range(0, 39);
                    default: addr = ssd_pkg::STORE_BASE + $urandom_range(40, STORE_BYTES - 1);
                endcase
                issue_item(mk(ssd_pkg::OP_IMM_WRITE, write_cmd_word(addr, $urandom_range(0, 63)),
                              ssd_pkg::IMM_BYTES, $urandom_range(0, 63), $urandom_range(0, 255)),
                           1'b0, ssd_pkg::ST_OK);
                steps = $urandom_range(1, 6);
                repeat (steps) begin
                    if ($urandom_range(0, 2) == 0) begin
                        issue_item(mk(ssd_pkg::OP_IMM_WRITE, $urandom, ssd_pkg::IMM_BYTES,
                                      $urandom_range(0, 63), $urandom_range(0, 255)),
                                   1'b0, ssd_pkg::ST_OK);
                    end else begin
                        if ($urandom_range(0, 7) != 0)
                            len = $urandom_range(0, STORE_BYTES - mirror_ptr);
                        else
                            len = $urandom_range(0, 127);
                        if (len != 0 && len <= 64 && $urandom_range(0, 5) != 0)
                            idx = $urandom_range(0, len - 1);
                        else
                            idx = $urandom_range(0, 63);
                        issue_item(mk(ssd_pkg::OP_XFER_WRITE, $urandom, len, idx,
                                      $urandom_range(0, 255)), 1'b0, ssd_pkg::ST_OK);
                    end
                end
            end else if (pick < 70) begin
                leave_payload();
                issue_item(mk(ssd_pkg::OP_IMM_WRITE, ssd_pkg::CMD_READ, ssd_pkg::IMM_BYTES,
                              $urandom_range(0, 63), $urandom_range(0, 255)),
                           1'b0, ssd_pkg::ST_OK);
                repeat ($urandom_range(1, 3))
                    issue_item(mk(ssd_pkg::OP_XFER_READ, $urandom, read_len(),
                                  $urandom_range(0, 63), $urandom_range(0, 255)),
                               1'b0, ssd_pkg::ST_OK);
            end else if (pick < 80) begin
                leave_payload();
                addr = $urandom_range(0, ssd_pkg::ROM_LIMIT - 1);
                issue_item(mk(ssd_pkg::OP_IMM_WRITE, {1'b0, addr, 6'($urandom_range(0, 63))},
                              ssd_pkg::IMM_BYTES, $urandom_range(0, 63),
                              $urandom_range(0, 255)), 1'b0, ssd_pkg::ST_OK);
                repeat ($urandom_range(1, 2))
                    issue_item(mk(ssd_pkg::OP_XFER_READ, $urandom, read_len(),
                                  $urandom_range(0, 63), $urandom_range(0, 255)),
                               1'b0, ssd_pkg::ST_OK);
            end else begin
                len = ($urandom_range(0, 9) < 3) ? ssd_pkg::IMM_BYTES : $urandom_range(0, 127);
                issue_item(mk(ssd_pkg::t_op'($urandom_range(0, 3)), $urandom, len,
                              $urandom_range(0, 63), $urandom_range(0, 255)),
                           1'b0, ssd_pkg::ST_OK);
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && awaited_answers.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ssd_pkg.sv
rtl/ssd_datapath.sv
rtl/ssd_ctrl.sv
rtl/serial_settings_sram_device_unit.sv
rtl/ssd_checker.sv
dv/tb_serial_settings_sram_device_unit.sv
